### hdl/b2da_pkg.sv
// Shared constants and types for the binary to decimal ASCII converter.
`timescale 1ns / 1ps

package b2da_pkg;

  localparam int VALUE_WIDTH = 32;

  // Number of decimal digits in the largest unsigned word, 2^w - 1.
  function automatic int dec_digits(input int w);
    logic [67:0] lim;
    logic [67:0] p;
    int          d;
    lim = (68'd1 << w) - 68'd1;
    p   = 68'd10;
    d   = 1;
    for (int i = 0; i < 20; i++) begin
      if (p <= lim) begin
        p = p * 68'd10;
        d = d + 1;
      end
    end
    return d;
  endfunction

  localparam int DIGITS  = dec_digits(VALUE_WIDTH);
  localparam int BCD_W   = 4 * DIGITS;
  localparam int CNT_W   = $clog2(DIGITS + 1);
  localparam int STEP_W  = $clog2(VALUE_WIDTH);

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  typedef logic [BCD_W-1:0]       bcd_t;
  typedef logic [VALUE_WIDTH-1:0] word_t;

endpackage

### hdl/binary_to_decimal_ascii_core.sv
// Top level: binary word to decimal ASCII text serializer.
`timescale 1ns / 1ps

// Usage
//   Input: raise start with operation (0 unsigned, 1 signed) and value.
//   The beat is taken on a rising edge where start is high and busy is low.
//   busy stays high until the last character of that number has been sent.
//   Output: one character beat per cycle on character/last, marked by strobe.
//   Characters come most significant digit first, no leading zeros; a
//   negative signed value is preceded by '-'. last marks the final digit.
//   The receiver cannot stall; each beat is present for one cycle only.
// Sequence (DIGITS = decimal digits of 2^VALUE_WIDTH - 1)
//   '-' (if any) appears the cycle after acceptance.
//   Double dabble of all VALUE_WIDTH bits through the shared shift/add-3
//   unit, then leading zeros are dropped and the digits sent, one per cycle.
//   A new number is taken only once the last digit is out; numbers never overlap.
// Reset: synchronous, active high; returns to idle with no beats pending.

module binary_to_decimal_ascii_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               operation,
  input  logic [b2da_pkg::VALUE_WIDTH-1:0]   value,
  output logic                               strobe,
  output logic [6:0]                         character,
  output logic                               last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                  state;
  logic [b2da_pkg::STEP_W-1:0] step;
  logic [b2da_pkg::CNT_W-1:0]  remaining;
  b2da_pkg::bcd_t              bcd_digits;
  b2da_pkg::word_t             shift_value;

  b2da_pkg::bcd_t              bcd_next;
  b2da_pkg::word_t             shift_value_next;
  logic                        negative;
  b2da_pkg::word_t             magnitude;
  logic [3:0]                  top_digit;
  logic                        accept;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign negative = operation && value[b2da_pkg::VALUE_WIDTH-1];
  // two's complement negate wraps, so the most negative value stays correct
  assign magnitude = negative ? (~value + b2da_pkg::word_t'(1)) : value;
  assign top_digit = bcd_digits[b2da_pkg::BCD_W-1 -: 4];

  // shared shift/add-3 unit, one bit of the magnitude per cycle
  b2da_dabble_step u_step (
    .bcd      (bcd_digits),
    .bin      (shift_value),
    .bcd_next (bcd_next),
    .bin_next (shift_value_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      step        <= '0;
      remaining   <= '0;
      strobe      <= 1'b0;
      bcd_digits  <= '0;
      shift_value <= '0;
      character   <= '0;
      last        <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state       <= ST_CONV;
            step        <= b2da_pkg::STEP_W'(b2da_pkg::VALUE_WIDTH - 1);
            bcd_digits  <= '0;
            shift_value <= magnitude;
            // sign goes out right away, digits follow after conversion
            strobe      <= negative;
            character   <= b2da_pkg::CHAR_MINUS;
            last        <= 1'b0;
          end else begin
            strobe <= 1'b0;
          end
        end
        ST_CONV: begin
          strobe      <= 1'b0;
          bcd_digits  <= bcd_next;
          shift_value <= shift_value_next;
          step        <= step - b2da_pkg::STEP_W'(1);
          if (step == '0) begin
            state     <= ST_SKIP;
            remaining <= b2da_pkg::CNT_W'(b2da_pkg::DIGITS);
          end
        end
        ST_SKIP: begin
          strobe <= 1'b0;
          // drop leading zeros, always keep at least one digit
          if (top_digit == 4'd0 && remaining != b2da_pkg::CNT_W'(1)) begin
            bcd_digits <= {bcd_digits[b2da_pkg::BCD_W-5:0], 4'd0};
            remaining  <= remaining - b2da_pkg::CNT_W'(1);
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          strobe     <= 1'b1;
          character  <= b2da_pkg::CHAR_ZERO + {3'b000, top_digit};
          last       <= (remaining == b2da_pkg::CNT_W'(1));
          bcd_digits <= {bcd_digits[b2da_pkg::BCD_W-5:0], 4'd0};
          remaining  <= remaining - b2da_pkg::CNT_W'(1);
          if (remaining == b2da_pkg::CNT_W'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          strobe <= 1'b0;
          state  <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/b2da_dabble_step.sv
// One shift-and-add-3 step of the double dabble conversion.
`timescale 1ns / 1ps

module b2da_dabble_step (
  input  b2da_pkg::bcd_t  bcd,
  input  b2da_pkg::word_t bin,
  output b2da_pkg::bcd_t  bcd_next,
  output b2da_pkg::word_t bin_next
);

  b2da_pkg::bcd_t adj;

  // digits of 5 or more get +3 so the shift carries into the next digit
  always_comb begin
    for (int i = 0; i < b2da_pkg::DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  assign bcd_next = {adj[b2da_pkg::BCD_W-2:0], bin[b2da_pkg::VALUE_WIDTH-1]};
  assign bin_next = {bin[b2da_pkg::VALUE_WIDTH-2:0], 1'b0};

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for binary_to_decimal_ascii_core: directed table, then random words.

module tb;
  import b2da_pkg::*;

  // Conversion modes as carried on the operation port.
  typedef enum logic {
    OP_UNSIGNED = 1'b0,
    OP_SIGNED   = 1'b1
  } conv_mode_e;

  // One character beat as the block sends it.
  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } text_beat_t;

  // Directed row: mode, word and, where obvious, the text typed in (right aligned,
  // unused leading bytes zero). An all-zero text means "use the predictor".
  typedef struct packed {
    conv_mode_e      mode;
    word_t           word;
    logic [8*11-1:0] txt;
  } dir_row_t;

  localparam logic [8*11-1:0] NO_TXT = '0;
  localparam int DIR_ROWS   = 22;
  localparam int RAND_ITEMS = 298;
  localparam int MAX_SHOWN  = 30;
  localparam int TAIL_CYCLES = 2 * (VALUE_WIDTH + DIGITS + 2);

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{OP_UNSIGNED, 32'h0000_0000, "0"},
    '{OP_SIGNED,   32'h0000_0000, "0"},
    '{OP_UNSIGNED, 32'h0000_0001, "1"},
    '{OP_SIGNED,   32'h0000_0001, "1"},
    '{OP_UNSIGNED, 32'h0000_0009, "9"},
    '{OP_UNSIGNED, 32'h0000_000A, "10"},
    '{OP_UNSIGNED, 32'hFFFF_FFFF, "4294967295"},
    '{OP_SIGNED,   32'hFFFF_FFFF, "-1"},
    '{OP_SIGNED,   32'h8000_0000, "-2147483648"},
    '{OP_UNSIGNED, 32'h8000_0000, "2147483648"},
    '{OP_SIGNED,   32'h7FFF_FFFF, "2147483647"},
    '{OP_SIGNED,   32'hFFFF_FFF6, "-10"},
    '{OP_UNSIGNED, 32'h3B9A_C9FF, "999999999"},
    '{OP_UNSIGNED, 32'h3B9A_CA00, "1000000000"},
    '{OP_SIGNED,   32'h8000_0001, NO_TXT},
    '{OP_UNSIGNED, 32'hAAAA_AAAA, NO_TXT},
    '{OP_SIGNED,   32'hAAAA_AAAA, NO_TXT},
    '{OP_UNSIGNED, 32'h5555_5555, NO_TXT},
    '{OP_SIGNED,   32'h5555_5555, NO_TXT},
    '{OP_UNSIGNED, 32'h0000_FFFF, NO_TXT},
    '{OP_SIGNED,   32'hFFFF_0000, NO_TXT},
    '{OP_UNSIGNED, 32'h1234_5678, NO_TXT}
  };

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic       operation;
  word_t      value;
  logic       strobe;
  logic [6:0] character;
  logic       last;

  text_beat_t pending_text_q[$];   // characters still owed by the block, oldest first
  int         err_count;
  int         beats_checked;
  int         words_sent;
  int         negatives_sent;

  binary_to_decimal_ascii_core DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .value     (value),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far above the slowest legal run of about 320 words with the longest gaps.
  initial begin
    #5_000_000;
    $display("Timeout: block stopped making progress");
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_SHOWN) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Predictor: decimal text of the word, sign first, MSD first, last on final digit.
  // The magnitude wraps at the word width, so the most negative value comes out right.
  task automatic push_decimal_text(input conv_mode_e mode, input word_t word);
    logic       neg;
    word_t      mag;
    logic [3:0] digs [DIGITS];
    int         n;
    neg = (mode == OP_SIGNED) && word[VALUE_WIDTH-1];
    mag = neg ? (~word + word_t'(1)) : word;
    n   = 0;
    do begin
      digs[n] = 4'(mag % 10);
      mag     = mag / 10;
      n++;
    end while (mag != 0);
    if (neg) pending_text_q.push_back('{CHAR_MINUS, 1'b0});
    for (int i = n - 1; i >= 0; i--)
      pending_text_q.push_back('{CHAR_ZERO + 7'(digs[i]), i == 0});
  endtask

  // Typed-in text from the directed table; zero bytes on the left are padding.
  task automatic push_typed_text(input logic [8*11-1:0] txt);
    text_beat_t beats[$];
    logic [7:0] ch;
    for (int b = 10; b >= 0; b--) begin
      ch = txt[8*b +: 8];
      if (ch != 8'd0) beats.push_back('{ch[6:0], 1'b0});
    end
    beats[beats.size()-1].last = 1'b1;
    foreach (beats[i]) pending_text_q.push_back(beats[i]);
  endtask

  // Sender: idle for gap cycles with junk on the fields, then offer the beat and
  // hold it until taken. Called and returns at a falling edge. With gap = 0 start
  // just stays high into the next word.
  task automatic send_word(input conv_mode_e mode, input word_t word,
                           input logic [8*11-1:0] txt, input int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) begin
        operation = 1'($urandom_range(0, 1));
        value     = word_t'($urandom);
        @(negedge clk);
      end
    end
    start     = 1'b1;
    operation = mode;
    value     = word;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Beat taken at this edge; the first character can show up next cycle.
    if (txt != NO_TXT) push_typed_text(txt);
    else push_decimal_text(mode, word);
    words_sent++;
    if (mode == OP_SIGNED && word[VALUE_WIDTH-1]) negatives_sent++;
    @(negedge clk);
  endtask

  // Wait until every owed character has come; ends on a falling edge.
  task automatic drain_text;
    while (pending_text_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly back to back or short gaps, now and then a long one so that the next
  // start lands on every phase of the conversion.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 17) return $urandom_range(1, 4);
    return $urandom_range(10, 70);
  endfunction

  // Random words weighted toward digit-count edges, tiny values and sign extremes.
  function automatic word_t pick_word();
    word_t p;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return word_t'($urandom);
      4:          return word_t'($urandom_range(0, 20));
      5: begin
        p = 1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        return p + word_t'($urandom_range(0, 2)) - word_t'(1);
      end
      6: begin
        case ($urandom_range(0, 2))
          0:       return 32'h8000_0000 + word_t'($urandom_range(0, 3));
          1:       return 32'hFFFF_FFFF - word_t'($urandom_range(0, 3));
          default: return 32'h7FFF_FFFF - word_t'($urandom_range(0, 3));
        endcase
      end
      default:    return word_t'($urandom) >> $urandom_range(0, 31);
    endcase
  endfunction

  // Checker: every strobe beat must match the oldest owed character.
  always @(posedge clk) begin : beat_check
    text_beat_t want;
    if (!rst && strobe) begin
      if (pending_text_q.size() == 0) begin
        report_mismatch($sformatf("beat with nothing owed: char=0x%02h last=%0b",
                                  character, last));
      end else begin
        want = pending_text_q.pop_front();
        beats_checked++;
        if (character !== want.character)
          report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                    character, want.character));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b on char 0x%02h",
                                    last, want.last, want.character));
      end
    end
  end

  initial begin
    err_count      = 0;
    beats_checked  = 0;
    words_sent     = 0;
    negatives_sent = 0;
    start          = 1'b0;
    operation      = OP_UNSIGNED;
    value          = '0;
    rst            = 1'b1;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Directed table: extremes, both modes, zero, digit-count boundaries.
    for (int i = 0; i < DIR_ROWS; i++)
      send_word(DIR_TABLE[i].mode, DIR_TABLE[i].word, DIR_TABLE[i].txt, pick_gap());

    // Sender holds off until the block has sent everything.
    start = 1'b0;
    drain_text();

    // Random words; one stretch runs back to back, one pause mid-way to drain.
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == 150) begin
        start = 1'b0;
        drain_text();
      end
      send_word(conv_mode_e'($urandom_range(0, 1)), pick_word(), NO_TXT,
                (i >= 60 && i < 100) ? 0 : pick_gap());
    end

    start = 1'b0;
    drain_text();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Converted %0d words (%0d negative in signed mode), %0d character beats checked",
             words_sent, negatives_sent, beats_checked);
    $display("Mismatches: %0d", err_count);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
hdl/b2da_pkg.sv
hdl/b2da_dabble_step.sv
hdl/binary_to_decimal_ascii_core.sv
tb/tb.sv
